>>> src/fhdc_pkg.sv
// Package for the frame header/data checksum checker.
// Holds counter width, frame position constants, fail codes, the byte transfer struct and a negation helper.
// No dependencies.
package fhdc_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [COUNT_WIDTH-1:0] HEADER_CHECK_POS = COUNT_WIDTH'(5);
    localparam logic [COUNT_WIDTH-1:0] DATA_START_POS   = COUNT_WIDTH'(6);
    localparam logic [COUNT_WIDTH-1:0] MIN_LAST_POS     = COUNT_WIDTH'(9);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        FAIL_NONE          = 3'd0,
        FAIL_SHORT         = 3'd1,
        FAIL_HEADER_ZERO   = 3'd2,
        FAIL_HEADER_MISMATCH = 3'd3,
        FAIL_DATA_ZERO     = 3'd4,
        FAIL_DATA_MISMATCH = 3'd5
    } fail_code_t;

    typedef struct packed {
        logic       fire;
        logic [7:0] data;
        logic       last;
    } byte_xfer_t;

    function automatic logic [7:0] negated(input logic [7:0] s);
        negated = 8'd0 - s;
    endfunction

endpackage

>>> src/frame_header_data_checksum_check_core.sv
// Top level of the frame header/data checksum checker.
// Streams frame bytes in and verdicts out; depends on fhdc_pkg and fhdc_frame_track.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tlast) carries one frame byte
//   per transfer; s_tlast marks the final byte of a frame. Bytes 0-4 form the
//   header, byte 5 its checksum (negated sum mod 256); bytes 6 to len-2 form the
//   data region and the final byte its checksum.
//   The master channel (m_tvalid/m_tready/m_tdata) carries one verdict per frame.
//   The verdict is registered and valid in the cycle after the transfer of the final byte.
//   Throughput: one byte per cycle while s_tready is high; the per-byte add feeds the
//   frame tracking registers and the compare sits between them and the output register.
//   Stall: while a verdict waits in the output register and m_tready is low,
//   s_tready drops; it stays high whenever the output register is empty or is
//   being drained in the same cycle, so draining a verdict costs no bubble.
//   Reset: rst_n clears the position counter, sums, header verdict and the
//   output valid flag; the first byte after reset starts a new frame.
module frame_header_data_checksum_check_core
    import fhdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] frame_valid, [3:1] fail_code, [7:4] zero
);

    byte_xfer_t xfer;
    fail_code_t verdict;

    logic       m_tvalid_reg, m_tvalid_next;
    fail_code_t code_reg, code_next;

    // Accept while the output register is free or drains this cycle
    assign s_tready = !m_tvalid_reg || m_tready;

    assign xfer.fire = s_tvalid && s_tready;
    assign xfer.data = s_tdata;
    assign xfer.last = s_tlast;

    fhdc_frame_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .xfer    (xfer),
        .verdict (verdict)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        code_next     = code_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        // load the verdict on the final byte of a frame
        if (xfer.fire && xfer.last)
        begin
            m_tvalid_next = 1'b1;
            code_next     = verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, code_reg, (code_reg == FAIL_NONE)};

    // A final byte transfer always yields a verdict next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("verdict missing after final byte");

    // A waiting, stalled verdict blocks new bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("byte accepted over a stalled verdict");

    // frame_valid agrees with the fail code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == FAIL_NONE)))
        else $error("frame_valid disagrees with fail code");

    // No verdict appears without a final byte transfer or an undrained one
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && !(s_tvalid && s_tready && s_tlast)) |=> !m_tvalid)
        else $error("spurious verdict");

endmodule

>>> src/fhdc_frame_track.sv
// Per-frame tracking of position, region sums and header verdict.
// Produces the verdict for the byte on its input; depends on fhdc_pkg.
module fhdc_frame_track
    import fhdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_xfer_t xfer,
    output fail_code_t verdict
);

    logic [COUNT_WIDTH-1:0] byte_count_reg, byte_count_next;
    logic [7:0]             running_sum_reg, running_sum_next;
    logic                   sum_nonzero_reg, sum_nonzero_next;
    fail_code_t             first_failure_reg, first_failure_next;

    // Verdict for a final byte at the current position
    always_comb
    begin
        if (byte_count_reg < MIN_LAST_POS)
            verdict = FAIL_SHORT;
        else if (first_failure_reg != FAIL_NONE)
            verdict = first_failure_reg;
        else if (!sum_nonzero_reg)
            verdict = FAIL_DATA_ZERO;
        else if (xfer.data != negated(running_sum_reg))
            verdict = FAIL_DATA_MISMATCH;
        else
            verdict = FAIL_NONE;
    end

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        running_sum_next   = running_sum_reg;
        sum_nonzero_next   = sum_nonzero_reg;
        first_failure_next = first_failure_reg;
        if (xfer.fire)
        begin
            if (xfer.last)
            begin
                // restart for the next frame
                byte_count_next    = '0;
                running_sum_next   = 8'd0;
                sum_nonzero_next   = 1'b0;
                first_failure_next = FAIL_NONE;
            end
            else
            begin
                if (byte_count_reg == HEADER_CHECK_POS)
                begin
                    if (!sum_nonzero_reg)
                        first_failure_next = FAIL_HEADER_ZERO;
                    else if (xfer.data != negated(running_sum_reg))
                        first_failure_next = FAIL_HEADER_MISMATCH;
                    running_sum_next = 8'd0;
                    sum_nonzero_next = 1'b0;
                end
                else if (byte_count_reg < HEADER_CHECK_POS ||
                         byte_count_reg >= DATA_START_POS)
                begin
                    running_sum_next = running_sum_reg + xfer.data;
                    sum_nonzero_next = sum_nonzero_reg | (xfer.data != 8'd0);
                end
                // saturate on very long frames
                if (byte_count_reg != COUNT_MAX)
                    byte_count_next = byte_count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            running_sum_reg   <= 8'd0;
            sum_nonzero_reg   <= 1'b0;
            first_failure_reg <= FAIL_NONE;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            running_sum_reg   <= running_sum_next;
            sum_nonzero_reg   <= sum_nonzero_next;
            first_failure_reg <= first_failure_next;
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for frame_header_data_checksum_check_core: drives frames byte by byte and checks
// every verdict against a cycle-free model of the header and data checksum rules.
// Depends on fhdc_pkg and the core RTL.
module tb_top
    import fhdc_pkg::*;
;

    // Watchdog limit, set well above the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 30;
    localparam int RAND_BYTES  = 900;
    localparam int TAIL_BYTES  = 150;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic       s_tlast;   // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] frame_valid, [3:1] fail_code, [7:4] zero

    frame_header_data_checksum_check_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // One row of the directed table. When typed is set, code is the verdict read straight
    // off the rules; otherwise the frame model supplies it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        fail_code_t code;
    } stim_row_t;

    stim_row_t dir_table [DIR_ROWS];

    // Frame model state: position in frame, region sum, region nonzero flag, header verdict.
    logic [COUNT_WIDTH-1:0] frame_pos;
    logic [7:0]             region_sum;
    logic                   region_hot;
    fail_code_t             header_verdict;

    fail_code_t verdict_q [$];   // verdicts owed by the core, oldest first
    fail_code_t want_code;

    int errors;
    int cycles;
    int bytes_sent;
    int verdicts_seen;
    int tx_pct;   // chance in percent of a sender gap before a byte
    int rx_pct;   // chance in percent of a receiver stall burst

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the frame model by one accepted byte; report a verdict on the final byte.
    task automatic track_byte(input logic [7:0] b, input logic l,
                              output logic done, output fail_code_t code);
        done = l;
        code = FAIL_NONE;
        if (l)
        begin
            // Short frames win over anything the header check found.
            if (frame_pos < MIN_LAST_POS)
                code = FAIL_SHORT;
            else if (header_verdict != FAIL_NONE)
                code = header_verdict;
            else if (!region_hot)
                code = FAIL_DATA_ZERO;
            else if (b != 8'd0 - region_sum)
                code = FAIL_DATA_MISMATCH;
            frame_pos      = '0;
            region_sum     = 8'd0;
            region_hot     = 1'b0;
            header_verdict = FAIL_NONE;
        end
        else
        begin
            if (frame_pos == HEADER_CHECK_POS)
            begin
                // Latch the header verdict, then clear the sum for the data region.
                if (!region_hot)
                    header_verdict = FAIL_HEADER_ZERO;
                else if (b != 8'd0 - region_sum)
                    header_verdict = FAIL_HEADER_MISMATCH;
                region_sum = 8'd0;
                region_hot = 1'b0;
            end
            else
            begin
                region_sum = region_sum + b;
                if (b != 8'd0)
                    region_hot = 1'b1;
            end
            // Hold the position at its maximum on very long frames.
            if (frame_pos != COUNT_MAX)
                frame_pos = frame_pos + 1'b1;
        end
    endtask

    // Present one byte at the falling edge and hold it until the core takes the transfer.
    task automatic push_byte(input logic [7:0] b, input logic l,
                             input logic typed, input fail_code_t code);
        logic       done;
        fail_code_t pred;
        if (tx_pct != 0 && $urandom_range(1, 100) <= tx_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = l;
        do
            @(posedge clk);
        while (!s_tready);
        track_byte(b, l, done, pred);
        if (done)
            verdict_q.push_back(typed ? code : pred);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Bias toward zero and all-ones so the zero-region rules and carries get exercised.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0, 1:    pick_byte = 8'h00;
            2:       pick_byte = 8'hFF;
            default: pick_byte = 8'($urandom);
        endcase
    endfunction

    // Build a frame with correct or corrupted checksums, truncate it to len bytes and send it.
    // A noise frame replaces every byte with a random one.
    task automatic send_frame(input int len, input bit noise, input bit zero_hdr,
                              input bit bad_hdr, input bit zero_dat, input bit bad_dat);
        logic [7:0] body [$];
        logic [7:0] acc;
        logic [7:0] b;
        acc = 8'd0;
        for (int i = 0; i < 5; i++)
        begin
            b = zero_hdr ? 8'd0 : pick_byte();
            body.push_back(b);
            acc = acc + b;
        end
        b = 8'd0 - acc;
        body.push_back(bad_hdr ? b ^ 8'($urandom_range(1, 255)) : b);
        acc = 8'd0;
        for (int i = 6; i < len - 1; i++)
        begin
            b = zero_dat ? 8'd0 : pick_byte();
            body.push_back(b);
            acc = acc + b;
        end
        b = 8'd0 - acc;
        body.push_back(bad_dat ? b ^ 8'($urandom_range(1, 255)) : b);
        for (int i = 0; i < len; i++)
            push_byte(noise ? pick_byte() : body[i], i == len - 1, 1'b0, FAIL_NONE);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0, 1:    pick_pct = 0;
            2:       pick_pct = 20;
            default: pick_pct = 60;
        endcase
    endfunction

    // Receiver: stall in random bursts while rx_pct allows it, otherwise take every verdict.
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rx_pct != 0 && $urandom_range(1, 100) <= rx_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // Check each verdict transfer against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                errors++;
                $display("%0t: verdict with none expected: expected none, actual m_tdata=%h",
                         $time, m_tdata);
            end
            else
            begin
                want_code = verdict_q.pop_front();
                verdicts_seen++;
                if (m_tdata[0] !== (want_code == FAIL_NONE))
                begin
                    errors++;
                    $display("%0t: frame_valid mismatch: expected %0b, actual %b",
                             $time, want_code == FAIL_NONE, m_tdata[0]);
                end
                if (m_tdata[3:1] !== want_code)
                begin
                    errors++;
                    $display("%0t: fail_code mismatch: expected %0d (%s), actual %0d",
                             $time, want_code, want_code.name(), m_tdata[3:1]);
                end
                if (m_tdata[7:4] !== 4'd0)
                begin
                    errors++;
                    $display("%0t: padding mismatch: expected 0, actual %h",
                             $time, m_tdata[7:4]);
                end
            end
        end
    end

    // Watchdog: end the run if it stalls.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                     $time, cycles, verdict_q.size());
            $display("[frame_header_data_checksum_check_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int len;
        int kind;
        int mark;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        s_tlast        = 1'b0;
        errors         = 0;
        cycles         = 0;
        bytes_sent     = 0;
        verdicts_seen  = 0;
        tx_pct         = 0;
        rx_pct         = 0;
        frame_pos      = '0;
        region_sum     = 8'd0;
        region_hot     = 1'b0;
        header_verdict = FAIL_NONE;

        // Directed frames: a one-byte frame, a nine-byte all-zero frame (short still wins),
        // a ten-byte all-zero frame (header zero), and a minimum-length good frame with
        // extreme data bytes.
        dir_table[0] = '{8'hFF, 1'b1, 1'b1, FAIL_SHORT};
        for (int i = 1; i < 9; i++)
            dir_table[i] = '{8'h00, 1'b0, 1'b0, FAIL_NONE};
        dir_table[9] = '{8'h00, 1'b1, 1'b1, FAIL_SHORT};
        for (int i = 10; i < 19; i++)
            dir_table[i] = '{8'h00, 1'b0, 1'b0, FAIL_NONE};
        dir_table[19] = '{8'h00, 1'b1, 1'b1, FAIL_HEADER_ZERO};
        dir_table[20] = '{8'h01, 1'b0, 1'b0, FAIL_NONE};
        dir_table[21] = '{8'h02, 1'b0, 1'b0, FAIL_NONE};
        dir_table[22] = '{8'h03, 1'b0, 1'b0, FAIL_NONE};
        dir_table[23] = '{8'h04, 1'b0, 1'b0, FAIL_NONE};
        dir_table[24] = '{8'h05, 1'b0, 1'b0, FAIL_NONE};
        dir_table[25] = '{8'hF1, 1'b0, 1'b0, FAIL_NONE};
        dir_table[26] = '{8'h80, 1'b0, 1'b0, FAIL_NONE};
        dir_table[27] = '{8'h00, 1'b0, 1'b0, FAIL_NONE};
        dir_table[28] = '{8'hFF, 1'b0, 1'b0, FAIL_NONE};
        dir_table[29] = '{8'h81, 1'b1, 1'b0, FAIL_NONE};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            push_byte(dir_table[i].data, dir_table[i].last, dir_table[i].typed,
                      dir_table[i].code);

        // Random frames: mostly well formed with random content and occasional zero or
        // corrupted regions, plus short frames and pure noise.
        mark = bytes_sent;
        while (bytes_sent - mark < RAND_BYTES)
        begin
            tx_pct = pick_pct();
            rx_pct = pick_pct();
            kind   = $urandom_range(0, 15);
            if (kind < 2)
                len = $urandom_range(1, 9);
            else if (kind == 2)
                len = $urandom_range(1, 40);
            else
                len = $urandom_range(10, 40);
            send_frame(len, kind == 2, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                       $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
        end

        // Tail at full rate on both sides.
        tx_pct = 0;
        rx_pct = 0;
        mark = bytes_sent;
        while (bytes_sent - mark < TAIL_BYTES)
        begin
            kind = $urandom_range(0, 7);
            len  = (kind == 0) ? $urandom_range(1, 9) : $urandom_range(10, 30);
            send_frame(len, 1'b0, 1'b0, $urandom_range(0, 5) == 0, 1'b0,
                       $urandom_range(0, 5) == 0);
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        // Drain owed verdicts, then keep the clock running to catch any stray transfer.
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d frame bytes over directed, stalled random and full-rate frames;",
                 bytes_sent);
        $display("checked %0d verdicts.", verdicts_seen);
        if (errors == 0)
            $display("[frame_header_data_checksum_check_core] OK");
        else
            $display("[frame_header_data_checksum_check_core] ERROR");
        $finish;
    end

endmodule
